/* src/bas_pkg.sv */
// Shared types and constants of the bilinear attenuation shader.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package bas_pkg;

  // Default store size and coordinate width
  localparam int DEF_MAP_COLS   = 256;
  localparam int DEF_MAP_ROWS   = 256;
  localparam int DEF_COORD_BITS = 12;

  // Widest map index over the legal store sizes (up to 1024)
  localparam int IDX_W = 10;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Scale above this uses the nearest map entry
  localparam logic [17:0] NEAREST_ABOVE = 18'd64880;
  localparam logic [16:0] ONE_Q16       = 17'h10000;

  // Configuration register indexes
  localparam logic [2:0] CFG_SCALE    = 3'd0;
  localparam logic [2:0] CFG_ORIGIN_X = 3'd1;
  localparam logic [2:0] CFG_ORIGIN_Y = 3'd2;
  localparam logic [2:0] CFG_LIGHT    = 3'd3;
  localparam logic [2:0] CFG_WIDTH    = 3'd4;
  localparam logic [2:0] CFG_HEIGHT   = 3'd5;

  // One classified word on its way from front to back
  typedef struct packed {
    logic             shade;    // 1 shades a pixel, 0 loads an entry
    logic             nearest;  // shade with nearest entry
    logic             wr_ok;    // load lands inside the store
    logic [IDX_W-1:0] ix;
    logic [IDX_W-1:0] iy;
    logic [16:0]      fx;
    logic [16:0]      fy;
    logic [7:0]       val;
    logic [7:0]       r;
    logic [7:0]       g;
    logic [7:0]       b;
  } bas_item_t;

endpackage

`default_nettype wire

/* src/bilinear_attenuation_shader.sv */
// Bilinear attenuation shader top level: configuration registers, front, queue, back.
// Depends on bas_pkg, bas_front, bas_queue and bas_back.
`timescale 1ns / 1ps
`default_nettype none

// The block takes one word per cycle, load or shade, while the queue has room, and
// presents one shaded pixel per shade word after the front register, the queue, the
// map read and weighting stages and the output register; load words give nothing.
// The rate is set by the four parity banks of the map, each read and written once per
// cycle, so all four bilinear neighbours come out of one read. A four-word queue
// decouples input from output stalls. Map entries hold no reset value and must be
// loaded before they are read. Write configuration only while no word is in flight.
module bilinear_attenuation_shader #(
  parameter int MAP_COLS   = bas_pkg::DEF_MAP_COLS,
  parameter int MAP_ROWS   = bas_pkg::DEF_MAP_ROWS,
  parameter int COORD_BITS = bas_pkg::DEF_COORD_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [17:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        command,
  input  wire logic [11:0] pos_x,
  input  wire logic [11:0] pos_y,
  input  wire logic [7:0]  attn_value,
  input  wire logic [7:0]  red,
  input  wire logic [7:0]  green,
  input  wire logic [7:0]  blue,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_red,
  output logic [7:0]       out_green,
  output logic [7:0]       out_blue
);
  import bas_pkg::*;

  logic [17:0] scale_q16;
  logic [7:0]  origin_x, origin_y;
  logic [15:0] lighting_factor;
  logic [8:0]  map_width, map_height;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      scale_q16       <= 18'd65536;
      origin_x        <= 8'd0;
      origin_y        <= 8'd0;
      lighting_factor <= 16'd4096;
      map_width       <= 9'd256;
      map_height      <= 9'd256;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_SCALE:    scale_q16       <= cfg_data;
        CFG_ORIGIN_X: origin_x        <= cfg_data[7:0];
        CFG_ORIGIN_Y: origin_y        <= cfg_data[7:0];
        CFG_LIGHT:    lighting_factor <= cfg_data[15:0];
        CFG_WIDTH:    map_width       <= cfg_data[8:0];
        CFG_HEIGHT:   map_height      <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  logic      q_full, push, pop, head_valid;
  bas_item_t push_item, head;

  bas_front #(
    .MAP_COLS  (MAP_COLS),
    .MAP_ROWS  (MAP_ROWS),
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .attn_value(attn_value),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .scale_q16 (scale_q16),
    .origin_x  (origin_x),
    .origin_y  (origin_y),
    .map_width (map_width),
    .map_height(map_height),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  bas_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .head_valid(head_valid),
    .head      (head)
  );

  bas_back #(
    .MAP_COLS(MAP_COLS),
    .MAP_ROWS(MAP_ROWS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .head_valid     (head_valid),
    .head           (head),
    .pop            (pop),
    .lighting_factor(lighting_factor),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue)
  );

endmodule

`default_nettype wire

/* src/bas_front.sv */
// Front part: accepts input words, forms source positions and classifies them.
// Depends on bas_pkg; feeds bas_queue.
`timescale 1ns / 1ps
`default_nettype none

module bas_front #(
  parameter int MAP_COLS   = bas_pkg::DEF_MAP_COLS,
  parameter int MAP_ROWS   = bas_pkg::DEF_MAP_ROWS,
  parameter int COORD_BITS = bas_pkg::DEF_COORD_BITS
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              command,
  input  wire logic [11:0]       pos_x,
  input  wire logic [11:0]       pos_y,
  input  wire logic [7:0]        attn_value,
  input  wire logic [7:0]        red,
  input  wire logic [7:0]        green,
  input  wire logic [7:0]        blue,
  input  wire logic [17:0]       scale_q16,
  input  wire logic [7:0]        origin_x,
  input  wire logic [7:0]        origin_y,
  input  wire logic [8:0]        map_width,
  input  wire logic [8:0]        map_height,
  input  wire logic              q_full,
  output logic                   push,
  output bas_pkg::bas_item_t     push_item
);
  import bas_pkg::*;

  localparam logic [11:0] CoordMask =
    (COORD_BITS >= 12) ? 12'hFFF : 12'((1 << COORD_BITS) - 1);

  logic        s1_valid;
  logic        s1_cmd;
  logic [11:0] s1_px, s1_py;
  logic [30:0] s1_sx, s1_sy;
  logic [7:0]  s1_val, s1_r, s1_g, s1_b;

  logic [11:0] pxm, pym;
  logic [29:0] prod_x, prod_y;
  logic        in_acc;

  // Map one axis position onto an index and a fraction
  function automatic logic [26:0] axis_map(logic [14:0] ip, logic [15:0] fr,
                                           logic [15:0] maxv, logic nearest);
    logic [15:0] i16;
    logic [15:0] o;
    logic [16:0] f;
    i16 = {1'b0, ip};
    f   = {1'b0, fr};
    o   = i16;
    if (nearest) begin
      if (i16 > maxv) o = maxv;
    end else if (i16 >= maxv) begin
      o = maxv - 16'd1;
      f = ONE_Q16;
    end
    return {o[IDX_W-1:0], f};
  endfunction

  assign in_ready = !s1_valid || !q_full;
  assign in_acc   = in_valid && in_ready;
  assign push     = s1_valid && !q_full;

  // Scale the texture coordinate into the map
  assign pxm    = pos_x & CoordMask;
  assign pym    = pos_y & CoordMask;
  assign prod_x = scale_q16 * pxm;
  assign prod_y = scale_q16 * pym;

  // Hold the word until the queue takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (push) begin
      s1_valid <= 1'b0;
    end
    if (in_acc) begin
      s1_cmd <= command;
      s1_px  <= pos_x;
      s1_py  <= pos_y;
      s1_sx  <= {1'b0, prod_x} + {7'd0, origin_x, 16'd0};
      s1_sy  <= {1'b0, prod_y} + {7'd0, origin_y, 16'd0};
      s1_val <= attn_value;
      s1_r   <= red;
      s1_g   <= green;
      s1_b   <= blue;
    end
  end

  // Classify: clamp map size, pick mode, clamp position at the edges
  logic [15:0] mw, mh, maxx, maxy;
  logic        near;
  logic [26:0] ax, ay;

  always_comb begin
    if (map_width < 9'd2) begin
      mw = 16'd2;
    end else if ({7'd0, map_width} > 16'(MAP_COLS)) begin
      mw = 16'(MAP_COLS);
    end else begin
      mw = {7'd0, map_width};
    end
    if (map_height < 9'd2) begin
      mh = 16'd2;
    end else if ({7'd0, map_height} > 16'(MAP_ROWS)) begin
      mh = 16'(MAP_ROWS);
    end else begin
      mh = {7'd0, map_height};
    end
    maxx = mw - 16'd1;
    maxy = mh - 16'd1;
    near = scale_q16 > NEAREST_ABOVE;
    ax   = axis_map(s1_sx[30:16], s1_sx[15:0], maxx, near);
    ay   = axis_map(s1_sy[30:16], s1_sy[15:0], maxy, near);

    push_item.shade   = s1_cmd;
    push_item.nearest = near;
    push_item.wr_ok   = ({20'd0, s1_px} < MAP_COLS) && ({20'd0, s1_py} < MAP_ROWS);
    push_item.val     = s1_val;
    push_item.r       = s1_r;
    push_item.g       = s1_g;
    push_item.b       = s1_b;
    if (s1_cmd) begin
      push_item.ix = ax[26:17];
      push_item.iy = ay[26:17];
      push_item.fx = ax[16:0];
      push_item.fy = ay[16:0];
    end else begin
      push_item.ix = s1_px[IDX_W-1:0];
      push_item.iy = s1_py[IDX_W-1:0];
      push_item.fx = 17'd0;
      push_item.fy = 17'd0;
    end
  end

endmodule

`default_nettype wire

/* src/bas_queue.sv */
// Short queue of classified words between front and back.
// Depends on bas_pkg for the word type and depth.
`timescale 1ns / 1ps
`default_nettype none

module bas_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire bas_pkg::bas_item_t push_item,
  output logic                    full,
  input  wire logic               pop,
  output logic                    head_valid,
  output bas_pkg::bas_item_t      head
);
  import bas_pkg::*;

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  bas_item_t       slots [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;

  assign full       = count == CntW'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head       = slots[rd_ptr];

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PtrW'(1);
      if (pop)  rd_ptr <= rd_ptr + PtrW'(1);
      if (push && !pop) begin
        count <= count + CntW'(1);
      end else if (pop && !push) begin
        count <= count - CntW'(1);
      end
    end
    if (push) slots[wr_ptr] <= push_item;
  end

endmodule

`default_nettype wire

/* src/bas_back.sv */
// Back part: banked attenuation map, bilinear weighting, shading, output register.
// Depends on bas_pkg; takes words from bas_queue.
`timescale 1ns / 1ps
`default_nettype none

module bas_back #(
  parameter int MAP_COLS = bas_pkg::DEF_MAP_COLS,
  parameter int MAP_ROWS = bas_pkg::DEF_MAP_ROWS
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               head_valid,
  input  wire bas_pkg::bas_item_t head,
  output logic                    pop,
  input  wire logic [15:0]        lighting_factor,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [7:0]              out_red,
  output logic [7:0]              out_green,
  output logic [7:0]              out_blue
);
  import bas_pkg::*;

  // Four banks by row and column parity, so the four neighbours never collide
  localparam int HalfCols = (MAP_COLS + 1) / 2;
  localparam int HalfRows = (MAP_ROWS + 1) / 2;
  localparam int Depth    = HalfCols * HalfRows;
  localparam int AddrW    = $clog2(Depth);

  logic adv;
  assign adv = !out_valid || out_ready;
  assign pop = adv && head_valid;

  logic [7:0] rd_data [4];

  genvar k;
  generate
    for (k = 0; k < 4; k++) begin : g_bank
      localparam logic PR = 1'(k >> 1);
      localparam logic PC = 1'(k & 1);
      logic [7:0]       mem [Depth];
      logic [10:0]      col, row, col_up, row_up;
      logic [31:0]      addr_full;
      logic [AddrW-1:0] addr;
      logic             we;

      // Pick the neighbour that falls into this bank
      always_comb begin
        col_up = {1'b0, head.ix} + 11'd1;
        row_up = {1'b0, head.iy} + 11'd1;
        if (head.ix[0] == PC || col_up > 11'(MAP_COLS - 1)) begin
          col = {1'b0, head.ix};
        end else begin
          col = col_up;
        end
        if (head.iy[0] == PR || row_up > 11'(MAP_ROWS - 1)) begin
          row = {1'b0, head.iy};
        end else begin
          row = row_up;
        end
        addr_full = 32'(row[10:1]) * 32'(HalfCols) + 32'(col[10:1]);
        addr      = addr_full[AddrW-1:0];
        we = pop && !head.shade && head.wr_ok && head.iy[0] == PR && head.ix[0] == PC;
      end

      always_ff @(posedge clk) begin
        if (we) mem[addr] <= head.val;
        if (adv) rd_data[k] <= mem[addr];
      end
    end
  endgenerate

  // Bilinear weights alongside the map read
  logic [16:0] wx0, wy0;
  logic [32:0] w00, w10, w01, w11;
  assign wx0 = ONE_Q16 - head.fx;
  assign wy0 = ONE_Q16 - head.fy;
  assign w00 = wx0 * wy0;
  assign w10 = head.fx * wy0;
  assign w01 = wx0 * head.fy;
  assign w11 = head.fx * head.fy;

  logic        b1_valid, b1_nearest, b1_ix0, b1_iy0;
  logic [32:0] b1_w00, b1_w10, b1_w01, b1_w11;
  logic [7:0]  b1_r, b1_g, b1_b;

  // Weighted sum of the four neighbours (or the nearest entry alone), colour times light gain
  logic [7:0]  e00, e10, e01, e11;
  logic [40:0] sum;
  logic [23:0] attn, lc_r, lc_g, lc_b;
  assign e00  = rd_data[{b1_iy0, b1_ix0}];
  assign e10  = rd_data[{b1_iy0, ~b1_ix0}];
  assign e01  = rd_data[{~b1_iy0, b1_ix0}];
  assign e11  = rd_data[{~b1_iy0, ~b1_ix0}];
  assign sum  = e00 * b1_w00 + e10 * b1_w10 + e01 * b1_w01 + e11 * b1_w11;
  assign attn = b1_nearest ? {e00, 16'd0} : sum[39:16];
  assign lc_r = lighting_factor * b1_r;
  assign lc_g = lighting_factor * b1_g;
  assign lc_b = lighting_factor * b1_b;

  logic        b2_valid;
  logic [23:0] b2_attn, b2_lc_r, b2_lc_g, b2_lc_b;

  // Final product, truncate and saturate
  function automatic logic [7:0] sat(logic [47:0] p);
    return (p[47:44] != 4'd0) ? 8'hFF : p[43:36];
  endfunction

  logic [47:0] p_r, p_g, p_b;
  assign p_r = b2_lc_r * b2_attn;
  assign p_g = b2_lc_g * b2_attn;
  assign p_b = b2_lc_b * b2_attn;

  // Advance every stage together unless the output word is held
  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid  <= 1'b0;
      b2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      b1_valid  <= pop && head.shade;
      b2_valid  <= b1_valid;
      out_valid <= b2_valid;
    end
    if (adv) begin
      b1_nearest <= head.nearest;
      b1_ix0     <= head.ix[0];
      b1_iy0     <= head.iy[0];
      b1_w00     <= w00;
      b1_w10     <= w10;
      b1_w01     <= w01;
      b1_w11     <= w11;
      b1_r       <= head.r;
      b1_g       <= head.g;
      b1_b       <= head.b;
      b2_attn    <= attn;
      b2_lc_r    <= lc_r;
      b2_lc_g    <= lc_g;
      b2_lc_b    <= lc_b;
      out_red    <= sat(p_r);
      out_green  <= sat(p_g);
      out_blue   <= sat(p_b);
    end
  end

endmodule

`default_nettype wire
